// File: hdl/dmxpk_pkg.sv
// Shared constants, opcodes and types of the DMX USB packet encoder.
// No dependencies; imported by every module of the block.
package dmxpk_pkg;

  localparam int unsigned MAX_CHANNELS = 512;
  localparam int unsigned MAX_ZERO_RUN = 100;

  localparam int unsigned ADDR_W  = $clog2(MAX_CHANNELS);
  localparam int unsigned POS_W   = ADDR_W + 1;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned RUN_W   = $clog2(MAX_ZERO_RUN + 2);
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned N_BYTES = 7;
  localparam int unsigned SLOT_W  = $clog2(N_BYTES);

  // channels kept back for the trailing six-channel payload
  localparam int unsigned TAIL_KEEP = 6;
  localparam int unsigned CHAN7_LEN = 7;

  localparam logic [OP_W-1:0] OP_CHAN7 = 3'd2;
  localparam logic [OP_W-1:0] OP_CHAN1 = 3'd3;
  localparam logic [OP_W-1:0] OP_START = 3'd4;
  localparam logic [OP_W-1:0] OP_SKIP  = 3'd5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

endpackage

// File: hdl/dmx_usb_packetizer.sv
// DMX USB packet encoder top level. A fetch request runs a zero-run scan plus
// payload gather through the single store port; one request in flight.
// A finished packet waits in the result register while the next request runs.
// After reset a clearing pass zeroes the store; requests stall.
// Depends on dmxpk_pkg, dmxpk_store, dmxpk_seq.
module dmx_usb_packetizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [dmxpk_pkg::ADDR_W-1:0]    channel_index_i,
  input  logic [dmxpk_pkg::BYTE_W-1:0]    channel_value_i,
  input  logic                            cfg_we_i,
  input  logic [dmxpk_pkg::CNT_W-1:0]     cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dmxpk_pkg::OP_W-1:0]      opcode_o,
  output logic [dmxpk_pkg::BYTE_W-1:0]    byte1_o,
  output logic [dmxpk_pkg::BYTE_W-1:0]    byte2_o,
  output logic [dmxpk_pkg::BYTE_W-1:0]    byte3_o,
  output logic [dmxpk_pkg::BYTE_W-1:0]    byte4_o,
  output logic [dmxpk_pkg::BYTE_W-1:0]    byte5_o,
  output logic [dmxpk_pkg::BYTE_W-1:0]    byte6_o,
  output logic [dmxpk_pkg::BYTE_W-1:0]    byte7_o,
  output logic                            last_packet_o
);
  import dmxpk_pkg::*;

  mem_req_t                       mem_req;
  logic [BYTE_W-1:0]              mem_rdata;
  logic                           clr_busy;
  logic [N_BYTES-1:0][BYTE_W-1:0] pkt;

  dmxpk_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  dmxpk_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .channel_index_i (channel_index_i),
    .channel_value_i (channel_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .clr_busy_i      (clr_busy),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .opcode_o        (opcode_o),
    .pkt_o           (pkt),
    .last_o          (last_packet_o)
  );

  assign byte1_o = pkt[0];
  assign byte2_o = pkt[1];
  assign byte3_o = pkt[2];
  assign byte4_o = pkt[3];
  assign byte5_o = pkt[4];
  assign byte6_o = pkt[5];
  assign byte7_o = pkt[6];

endmodule

// File: hdl/dmxpk_store.sv
// Channel level store: one-port synchronous RAM with registered read data.
// Clears itself after reset. Depends on dmxpk_pkg.
module dmxpk_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dmxpk_pkg::mem_req_t         req_i,
  output logic [dmxpk_pkg::BYTE_W-1:0] rdata_o,
  output logic                        clr_busy_o
);
  import dmxpk_pkg::*;

  logic [BYTE_W-1:0] mem_q [MAX_CHANNELS];
  logic [BYTE_W-1:0] rdata_q;
  logic [POS_W-1:0]  clr_cnt_q;
  logic              clr_busy;

  assign clr_busy   = clr_cnt_q < POS_W'(MAX_CHANNELS);
  assign clr_busy_o = clr_busy;
  assign rdata_o    = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy) begin
      clr_cnt_q <= clr_cnt_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      mem_q[clr_cnt_q[ADDR_W-1:0]] <= '0;
    end else if (req_i.en && req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.we) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

endmodule

// File: hdl/dmxpk_seq.sv
// Packet sequencer: zero-run scan and payload gather over the channel store,
// frame cursor, channel count register and result register. Uses dmxpk_pkg.
module dmxpk_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [dmxpk_pkg::ADDR_W-1:0]      channel_index_i,
  input  logic [dmxpk_pkg::BYTE_W-1:0]      channel_value_i,
  input  logic                              cfg_we_i,
  input  logic [dmxpk_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  logic                              clr_busy_i,
  output dmxpk_pkg::mem_req_t               mem_req_o,
  input  logic [dmxpk_pkg::BYTE_W-1:0]      mem_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dmxpk_pkg::OP_W-1:0]        opcode_o,
  output logic [dmxpk_pkg::N_BYTES-1:0][dmxpk_pkg::BYTE_W-1:0] pkt_o,
  output logic                              last_o
);
  import dmxpk_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRD  = 3'd1;
  localparam logic [2:0] ST_SCHK = 3'd2;
  localparam logic [2:0] ST_GRD  = 3'd3;
  localparam logic [2:0] ST_GCAP = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(N_BYTES - 1);

  logic [2:0]                           state_q;
  logic [CNT_W-1:0]                     cnt_q;
  logic [POS_W-1:0]                     cur_q;
  logic                                 started_q;
  logic [POS_W-1:0]                     s_q;
  logic [RUN_W-1:0]                     r_q;
  logic                                 start_q;
  logic                                 probe_q;
  logic [OP_W-1:0]                      op_q;
  logic [N_BYTES-1:0][BYTE_W-1:0]       pkt_q;
  logic [SLOT_W-1:0]                    slot_q;
  logic [SLOT_W-1:0]                    fin_q;
  logic [POS_W-1:0]                     gat_q;
  logic                                 oob_q;
  logic                                 last_q;
  logic                                 out_valid_q;
  logic [OP_W-1:0]                      out_op_q;
  logic [N_BYTES-1:0][BYTE_W-1:0]       out_pkt_q;
  logic                                 out_last_q;

  logic [POS_W-1:0]  m_w;
  logic [BYTE_W-1:0] lvl_w;
  logic [BYTE_W-1:0] cnt_byte_w;
  logic [POS_W-1:0]  rd_pos_w;
  logic [POS_W-1:0]  gat_nxt_w;
  logic              new_last_w;
  logic              scan_go_w;
  logic              acc_w;
  logic              push_w;

  assign m_w = (cnt_q > CNT_W'(MAX_CHANNELS)) ? POS_W'(MAX_CHANNELS) : POS_W'(cnt_q);
  assign lvl_w      = oob_q ? '0 : mem_rdata_i;
  assign cnt_byte_w = BYTE_W'(r_q) + BYTE_W'(start_q);
  assign rd_pos_w   = (state_q == ST_GRD) ? gat_q : s_q;
  assign gat_nxt_w  = gat_q + POS_W'(1);
  assign new_last_w = gat_nxt_w >= m_w;
  assign scan_go_w  = probe_q ||
                      ((r_q < RUN_W'(MAX_ZERO_RUN)) &&
                       (({1'b0, s_q} + (POS_W+1)'(TAIL_KEEP)) < {1'b0, m_w}));

  assign in_stall_o = (state_q != ST_IDLE) || clr_busy_i || cfg_we_i;
  assign acc_w      = in_valid_i && !in_stall_o;
  assign push_w     = (state_q == ST_DONE) && !cfg_we_i && (!out_valid_q || !out_stall_i);

  assign out_valid_o = out_valid_q;
  assign opcode_o    = out_op_q;
  assign pkt_o       = out_pkt_q;
  assign last_o      = out_last_q;

  always_comb begin
    mem_req_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_w && kind_i == KIND_WRITE) begin
          mem_req_o.en    = 1'b1;
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = channel_index_i;
          mem_req_o.wdata = channel_value_i;
        end
      end
      ST_SRD: begin
        mem_req_o.en   = scan_go_w;
        mem_req_o.addr = s_q[ADDR_W-1:0];
      end
      ST_GRD: begin
        mem_req_o.en   = 1'b1;
        mem_req_o.addr = gat_q[ADDR_W-1:0];
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= CNT_W'(6);
      cur_q       <= '0;
      started_q   <= 1'b0;
      s_q         <= '0;
      r_q         <= '0;
      start_q     <= 1'b0;
      probe_q     <= 1'b0;
      op_q        <= OP_START;
      pkt_q       <= '0;
      slot_q      <= '0;
      fin_q       <= '0;
      gat_q       <= '0;
      oob_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_op_q    <= OP_START;
      out_pkt_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      oob_q       <= rd_pos_w >= POS_W'(MAX_CHANNELS);
      out_valid_q <= push_w || (out_valid_q && out_stall_i);
      if (cfg_we_i) begin
        cnt_q     <= cfg_wdata_i;
        cur_q     <= '0;
        started_q <= 1'b0;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (acc_w && kind_i == KIND_FETCH) begin
              pkt_q <= '0;
              r_q   <= '0;
              if (!started_q || cur_q >= m_w) begin
                op_q    <= OP_START;
                start_q <= 1'b1;
                probe_q <= 1'b0;
                s_q     <= '0;
                state_q <= ST_SRD;
              end else if ((cur_q + POS_W'(CHAN7_LEN)) < m_w) begin
                start_q <= 1'b0;
                probe_q <= 1'b1;
                s_q     <= cur_q;
                state_q <= ST_SRD;
              end else begin
                start_q <= 1'b0;
                probe_q <= 1'b0;
                op_q    <= OP_CHAN1;
                gat_q   <= cur_q;
                slot_q  <= '0;
                fin_q   <= '0;
                state_q <= ST_GRD;
              end
            end
          end
          ST_SRD: begin
            if (scan_go_w) begin
              state_q <= ST_SCHK;
            end else begin
              pkt_q[0] <= cnt_byte_w;
              gat_q    <= s_q;
              slot_q   <= SLOT_W'(1);
              fin_q    <= SLOT_LAST;
              state_q  <= ST_GRD;
            end
          end
          ST_SCHK: begin
            if (probe_q) begin
              probe_q <= 1'b0;
              if (lvl_w != '0) begin
                op_q     <= OP_CHAN7;
                pkt_q[0] <= lvl_w;
                gat_q    <= s_q + POS_W'(1);
                slot_q   <= SLOT_W'(1);
                fin_q    <= SLOT_LAST;
                state_q  <= ST_GRD;
              end else begin
                op_q    <= OP_SKIP;
                s_q     <= s_q + POS_W'(1);
                r_q     <= RUN_W'(1);
                state_q <= ST_SRD;
              end
            end else if (lvl_w == '0) begin
              s_q     <= s_q + POS_W'(1);
              r_q     <= r_q + RUN_W'(1);
              state_q <= ST_SRD;
            end else begin
              pkt_q[0] <= cnt_byte_w;
              gat_q    <= s_q;
              slot_q   <= SLOT_W'(1);
              fin_q    <= SLOT_LAST;
              state_q  <= ST_GRD;
            end
          end
          ST_GRD: begin
            state_q <= ST_GCAP;
          end
          ST_GCAP: begin
            pkt_q[slot_q] <= lvl_w;
            if (slot_q == fin_q) begin
              last_q    <= new_last_w;
              cur_q     <= new_last_w ? '0 : gat_nxt_w;
              started_q <= !new_last_w;
              state_q   <= ST_DONE;
            end else begin
              slot_q  <= slot_q + SLOT_W'(1);
              gat_q   <= gat_nxt_w;
              state_q <= ST_GRD;
            end
          end
          ST_DONE: begin
            if (push_w) begin
              out_op_q    <= op_q;
              out_pkt_q   <= pkt_q;
              out_last_q  <= last_q;
              state_q     <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_i |-> !mem_req_o.en)
    else $error("store request during clearing pass");

  a_cursor_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (cur_q < m_w))
    else $error("frame cursor beyond frame end while started");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCAP) |-> (slot_q <= fin_q))
    else $error("gather slot past final slot");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCHK) |-> (r_q < RUN_W'(MAX_ZERO_RUN)))
    else $error("zero run longer than limit");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for dmx_usb_packetizer: a directed request table, then random phases
// of channel writes and fetches; each packet is compared with an in-bench encoder or a
// typed row packet. Depends on dmxpk_pkg and dmx_usb_packetizer.
module tb_top;
  import dmxpk_pkg::*;

  localparam int CHANS    = int'(MAX_CHANNELS);
  localparam int RUN_CAP  = int'(MAX_ZERO_RUN);
  localparam int KEEP     = int'(TAIL_KEEP);
  localparam int SEVEN    = int'(CHAN7_LEN);
  localparam int N_ITEMS  = 1400;
  localparam int PAUSE    = 16;
  localparam int LIMIT    = 2_000_000;
  localparam int IDLE_PCT = 21;
  localparam int N_DIR    = 28;

  typedef struct packed {
    logic [OP_W-1:0]              opcode;
    logic [1:N_BYTES][BYTE_W-1:0] bytes_f;
    logic                         last;
  } dmx_packet_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_FETCH, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         act;
    logic [ADDR_W-1:0] idx;
    logic [BYTE_W-1:0] val;
    logic [CNT_W-1:0]  count;
    logic              typed;
    dmx_packet_t       want;
  } row_t;

  row_t dir_rows [N_DIR] = '{
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b1, {OP_START, 8'd1, 48'd0, 1'b1}},
    '{ROW_WRITE, 9'd511, 8'd255, 10'd0,    1'b0, '0},
    '{ROW_WRITE, 9'd0,   8'd255, 10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b1, {OP_START, 8'd1, 8'd255, 40'd0, 1'b1}},
    '{ROW_WRITE, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_WRITE, 9'd3,   8'd1,   10'd0,    1'b0, '0},
    '{ROW_WRITE, 9'd5,   8'd128, 10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_CFG,   9'd0,   8'd0,   10'd20,   1'b0, '0},
    '{ROW_WRITE, 9'd9,   8'd7,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_WRITE, 9'd9,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_CFG,   9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b1,
      {OP_START, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd128, 1'b1}},
    '{ROW_WRITE, 9'd3,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_WRITE, 9'd5,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_CFG,   9'd0,   8'd0,   10'd1023, 1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0},
    '{ROW_CFG,   9'd0,   8'd0,   10'd7,    1'b0, '0},
    '{ROW_FETCH, 9'd0,   8'd0,   10'd0,    1'b0, '0}
  };

  logic [CNT_W-1:0] edge_counts [10] = '{
    10'd1, 10'd512, 10'd0, 10'd1023, 10'd6, 10'd7, 10'd8, 10'd13, 10'd14, 10'd513
  };

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              kind_i          = KIND_WRITE;
  logic [ADDR_W-1:0] channel_index_i = '0;
  logic [BYTE_W-1:0] channel_value_i = '0;
  logic              cfg_we_i        = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i     = '0;
  logic              out_stall_i     = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [OP_W-1:0]   opcode_o;
  logic [BYTE_W-1:0] byte1_o, byte2_o, byte3_o, byte4_o, byte5_o, byte6_o, byte7_o;
  logic              last_packet_o;

  logic [BYTE_W-1:0] level_mem [CHANS];
  logic [CNT_W-1:0]  chan_count = 10'd6;
  int                cursor     = 0;
  logic              started    = 1'b0;
  dmx_packet_t       pending_packets [$];
  int                fail_cnt   = 0;
  int                cycle_cnt  = 0;
  logic              calm       = 1'b0;

  dmx_usb_packetizer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .channel_index_i (channel_index_i),
    .channel_value_i (channel_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .opcode_o        (opcode_o),
    .byte1_o         (byte1_o),
    .byte2_o         (byte2_o),
    .byte3_o         (byte3_o),
    .byte4_o         (byte4_o),
    .byte5_o         (byte5_o),
    .byte6_o         (byte6_o),
    .byte7_o         (byte7_o),
    .last_packet_o   (last_packet_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] level_of(input int ch);
    if (ch < 0 || ch >= CHANS) return '0;
    return level_mem[ch];
  endfunction

  // Applies one request to the bench copy of the store; returns 1 with the packet on a fetch.
  function automatic logic encode_request(input logic kind, input logic [ADDR_W-1:0] idx,
                                          input logic [BYTE_W-1:0] val,
                                          output dmx_packet_t pkt);
    int frame_end;
    int pos;
    int run_end;
    int k;
    pkt = '0;
    if (kind == KIND_WRITE) begin
      level_mem[idx] = val;
      return 1'b0;
    end
    frame_end = (int'(chan_count) > CHANS) ? CHANS : int'(chan_count);
    pos = cursor;
    if (started && pos >= frame_end) started = 1'b0;
    if (!started) begin
      pos = 0;
      while (pos < RUN_CAP && level_of(pos) == '0 && pos < frame_end - KEEP) pos++;
      pkt.opcode     = OP_START;
      pkt.bytes_f[1] = 8'(pos + 1);
      for (k = 0; k < KEEP; k++) pkt.bytes_f[2 + k] = level_of(pos + k);
      pos += KEEP;
      started = 1'b1;
    end else if (pos < frame_end - SEVEN) begin
      if (level_of(pos) == '0) begin
        run_end = pos + 1;
        while (run_end < frame_end - KEEP && run_end - pos < RUN_CAP &&
               level_of(run_end) == '0)
          run_end++;
        pkt.opcode     = OP_SKIP;
        pkt.bytes_f[1] = 8'(run_end - pos);
        for (k = 0; k < KEEP; k++) pkt.bytes_f[2 + k] = level_of(run_end + k);
        pos = run_end + KEEP;
      end else begin
        pkt.opcode = OP_CHAN7;
        for (k = 0; k < SEVEN; k++) pkt.bytes_f[1 + k] = level_of(pos + k);
        pos += SEVEN;
      end
    end else begin
      pkt.opcode     = OP_CHAN1;
      pkt.bytes_f[1] = level_of(pos);
      pos += 1;
    end
    if (pos >= frame_end) begin
      pkt.last = 1'b1;
      cursor   = 0;
      started  = 1'b0;
    end else begin
      cursor = pos;
    end
    return 1'b1;
  endfunction

  task automatic issue_request(input logic kind, input logic [ADDR_W-1:0] idx,
                               input logic [BYTE_W-1:0] val);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    channel_index_i <= idx;
    channel_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Only written with no packet outstanding; the pause lets a trailing write finish.
  task automatic write_channel_count(input logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_packets.size() != 0) @(posedge clk_i);
    repeat (PAUSE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    chan_count = value;
    cursor     = 0;
    started    = 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt   <= cycle_cnt + 1;
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    if (cycle_cnt == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    dmx_packet_t got;
    dmx_packet_t want;
    int          k;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {opcode_o, byte1_o, byte2_o, byte3_o, byte4_o, byte5_o, byte6_o, byte7_o,
             last_packet_o};
      if (pending_packets.size() == 0) begin
        $error("packet with no fetch request pending");
        fail_cnt++;
      end else begin
        want = pending_packets.pop_front();
        if (got.opcode !== want.opcode) begin
          $error("opcode: expected %0d, got %0d", want.opcode, got.opcode);
          fail_cnt++;
        end
        for (k = 1; k <= N_BYTES; k++) begin
          if (got.bytes_f[k] !== want.bytes_f[k]) begin
            $error("byte%0d: expected %0d, got %0d", k, want.bytes_f[k], got.bytes_f[k]);
            fail_cnt++;
          end
        end
        if (got.last !== want.last) begin
          $error("last_packet: expected %0d, got %0d", want.last, got.last);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    dmx_packet_t       pkt;
    int                issued;
    int                phase_no;
    int                fetch_pct;
    int                zero_pct;
    int                span;
    int                n_req;
    logic [CNT_W-1:0]  count;
    logic              kind;
    logic [ADDR_W-1:0] idx;
    logic [BYTE_W-1:0] val;
    issued   = 0;
    phase_no = 0;
    foreach (level_mem[i]) level_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].act == ROW_CFG) begin
        write_channel_count(dir_rows[r].count);
      end else begin
        kind = (dir_rows[r].act == ROW_FETCH) ? KIND_FETCH : KIND_WRITE;
        issue_request(kind, dir_rows[r].idx, dir_rows[r].val);
        if (encode_request(kind, dir_rows[r].idx, dir_rows[r].val, pkt))
          pending_packets.insert(pending_packets.size(),
                                 dir_rows[r].typed ? dir_rows[r].want : pkt);
        issued++;
      end
    end

    // phases: new frame size, then a burst of writes and fetches, indices mostly in the frame
    while (issued < N_ITEMS) begin
      calm = (phase_no >= 3 && phase_no < 6);
      if ($urandom_range(0, 1) == 0)
        count = edge_counts[$urandom_range(0, 9)];
      else
        count = CNT_W'($urandom_range(0, 1023));
      write_channel_count(count);
      span      = (count == '0) ? 1 : ((int'(count) > CHANS) ? CHANS : int'(count));
      fetch_pct = $urandom_range(40, 90);
      zero_pct  = $urandom_range(20, 95);
      n_req     = $urandom_range(40, 160);
      repeat (n_req) begin
        kind = ($urandom_range(0, 99) < fetch_pct) ? KIND_FETCH : KIND_WRITE;
        if ($urandom_range(0, 99) < 85)
          idx = ADDR_W'($urandom_range(0, span - 1));
        else
          idx = ADDR_W'($urandom());
        if ($urandom_range(0, 99) < zero_pct)
          val = '0;
        else
          val = BYTE_W'($urandom_range(0, 255));
        issue_request(kind, idx, val);
        if (encode_request(kind, idx, val, pkt))
          pending_packets.insert(pending_packets.size(), pkt);
        issued++;
      end
      phase_no++;
    end

    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending_packets.size() != 0) @(posedge clk_i);
    repeat (PAUSE) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/dmxpk_pkg.sv
hdl/dmxpk_store.sv
hdl/dmxpk_seq.sv
hdl/dmx_usb_packetizer.sv
tb/tb_top.sv
